// ===== hw/rtl/binary32_float_adder_unit_assert.svh =====
// Assertion macros for the binary32 float adder unit.
`ifndef BINARY32_FLOAT_ADDER_UNIT_ASSERT_SVH
`define BINARY32_FLOAT_ADDER_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define BFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants and stage types of the binary32 float adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bfa_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ExpW   = 8;
  localparam int unsigned FracW  = 23;
  localparam int unsigned SigW   = 24;
  localparam logic [4:0]  MaxShift = 5'd31;
  localparam logic [ExpW-1:0] ExpMax = 8'hFF;

  // Stage 1: unpacked, aligned operands.
  typedef struct packed {
    logic            bypass;
    logic [WordW-1:0] bypass_val;
    logic            sign_a;
    logic            sign_b;
    logic [ExpW-1:0] exp;
    logic [SigW-1:0] sig_a;
    logic [SigW-1:0] sig_b;
  } st1_t;

  // Stage 2: signed magnitude sum.
  typedef struct packed {
    logic            bypass;
    logic [WordW-1:0] bypass_val;
    logic            sign;
    logic [ExpW-1:0] exp;
    logic [SigW:0]   sig;
  } st2_t;

  // Stage 3: leading one position.
  typedef struct packed {
    logic            bypass;
    logic [WordW-1:0] bypass_val;
    logic            sign;
    logic [ExpW-1:0] exp;
    logic [SigW:0]   sig;
    logic [4:0]      top;
  } st3_t;

endpackage
`default_nettype wire

// ===== hw/rtl/binary32_float_adder_unit.sv =====
// ----------------------------------------------------------------------------
// binary32_float_adder_unit
// Four-stage truncating binary32 adder with a valid/stall pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i with operand_a_i and operand_b_i; the block
//   raises in_stall_o when the pipeline is full and the receiver is stalled.
//   Output channel: out_valid_o with sum_o; the receiver drives out_stall_i.
//   An accepted request passes through the four pipeline registers
//   (unpack/align, add, leading-one search, normalize/pack), each of which
//   holds one request; sum_o is the normalize/pack register. One request is
//   taken every cycle while in_stall_o is low.
//   A stall on the output holds the last stage; earlier stages keep filling
//   bubbles, so nothing is lost or repeated. in_stall_o is high only when
//   every stage holds a request and the output is stalled.
//   Reset clears all valid bits; the block is empty after reset.
//   An all-zero operand passes the other operand through. NaN and infinity
//   are treated as large numbers; exponent overflow gives infinity and
//   underflow gives a subnormal. Rounding is by truncation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "binary32_float_adder_unit_assert.svh"
module binary32_float_adder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] operand_a_i,
  input  wire logic [31:0] operand_b_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      sum_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;
  bfa_pkg::st1_t s1_d, s1_q;
  bfa_pkg::st2_t s2_d, s2_q;
  bfa_pkg::st3_t s3_d, s3_q;
  logic [31:0] sum_d, sum_q;

  // Advance a stage when its successor is free or moving.
  assign adv4 = !v4_q || !out_stall_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_stall_o = !adv1;

  // Stage 1: unpack and align the smaller operand.
  always_comb begin
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic [7:0]  diff;
    logic [4:0]  sh;
    ea = operand_a_i[30:23];
    eb = operand_b_i[30:23];
    ma = {(ea != 8'd0), operand_a_i[22:0]};
    mb = {(eb != 8'd0), operand_b_i[22:0]};
    if (ea == 8'd0) ea = 8'd1;
    if (eb == 8'd0) eb = 8'd1;
    s1_d.bypass     = (operand_a_i == 32'd0) || (operand_b_i == 32'd0);
    s1_d.bypass_val = (operand_a_i == 32'd0) ? operand_b_i : operand_a_i;
    s1_d.sign_a     = operand_a_i[31];
    s1_d.sign_b     = operand_b_i[31];
    if (ea >= eb) begin
      diff = ea - eb;
      sh = (diff > 8'd31) ? bfa_pkg::MaxShift : diff[4:0];
      s1_d.exp   = ea;
      s1_d.sig_a = ma;
      s1_d.sig_b = mb >> sh;
    end else begin
      diff = eb - ea;
      sh = (diff > 8'd31) ? bfa_pkg::MaxShift : diff[4:0];
      s1_d.exp   = eb;
      s1_d.sig_a = ma >> sh;
      s1_d.sig_b = mb;
    end
  end

  // Stage 2: add or subtract by magnitude.
  always_comb begin
    s2_d.bypass     = s1_q.bypass;
    s2_d.bypass_val = s1_q.bypass_val;
    s2_d.exp        = s1_q.exp;
    if (s1_q.sign_a == s1_q.sign_b) begin
      s2_d.sig  = {1'b0, s1_q.sig_a} + {1'b0, s1_q.sig_b};
      s2_d.sign = s1_q.sign_a;
    end else if (s1_q.sig_a > s1_q.sig_b) begin
      s2_d.sig  = {1'b0, s1_q.sig_a - s1_q.sig_b};
      s2_d.sign = s1_q.sign_a;
    end else begin
      s2_d.sig  = {1'b0, s1_q.sig_b - s1_q.sig_a};
      s2_d.sign = s1_q.sign_b;
    end
  end

  // Stage 3: find the leading one.
  always_comb begin
    s3_d.bypass     = s2_q.bypass;
    s3_d.bypass_val = s2_q.bypass_val;
    s3_d.sign       = s2_q.sign;
    s3_d.exp        = s2_q.exp;
    s3_d.sig        = s2_q.sig;
    s3_d.top        = 5'd0;
    for (int i = 0; i < 25; i++) begin
      if (s2_q.sig[i]) s3_d.top = 5'(i);
    end
  end

  // Stage 4: normalize, check range and pack.
  always_comb begin
    logic [24:0] sig;
    logic [8:0]  e;
    logic [4:0]  need;
    sig  = s3_q.sig;
    e    = {1'b0, s3_q.exp};
    need = 5'd23 - s3_q.top;
    if (s3_q.top == 5'd24) begin
      sig = sig >> 1;
      e   = e + 9'd1;
    end else if (s3_q.top < 5'd23) begin
      if (e > {4'd0, need}) begin
        sig = sig << need;
        e   = e - {4'd0, need};
      end else begin
        sig = sig << (e[7:0] - 8'd1);
        e   = 9'd0;
      end
    end
    if (s3_q.bypass) begin
      sum_d = s3_q.bypass_val;
    end else if (s3_q.sig == 25'd0) begin
      sum_d = 32'd0;
    end else if (e >= 9'd255) begin
      sum_d = {s3_q.sign, bfa_pkg::ExpMax, 23'd0};
    end else begin
      sum_d = {s3_q.sign, e[7:0], sig[22:0]};
    end
  end

  // Hold valid bits; clear at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  // Advance payload with its valid bit.
  always_ff @(posedge clk_i) begin
    if (adv1) s1_q <= s1_d;
    if (adv2) s2_q <= s2_d;
    if (adv3) s3_q <= s3_d;
    if (adv4) sum_q <= sum_d;
  end

  assign out_valid_o = v4_q;
  assign sum_o       = sum_q;

  `BFA_ASSERT_NEXT(a_hold_out, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(sum_o))
  `BFA_ASSERT_IMPL(a_stall_full, clk_i, rst_ni, in_stall_o, v1_q && v2_q && v3_q && v4_q && out_stall_i)
  `BFA_ASSERT_NEXT(a_fill, clk_i, rst_ni, in_valid_i && !in_stall_o, v1_q)

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives operand pairs into the binary32 adder under random idle and stall,
// predicts each truncated sum and compares results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] sum_o;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] sum_queue[$];

  localparam int unsigned QuietLimit = 2000;

  binary32_float_adder_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operand_a_i, .operand_b_i,
    .out_valid_o, .out_stall_i, .sum_o
  );

  always #4 clk_i = ~clk_i;

  // Predict the truncated binary32 sum of two patterns.
  function automatic logic [31:0] predict_sum(logic [31:0] a, logic [31:0] b);
    logic        sa, sb, s;
    logic [8:0]  ea, eb, e, need;
    logic [31:0] ma, mb, sig, shift_amt;
    int          top;
    if (a == 0) return b;
    if (b == 0) return a;
    sa = a[31]; sb = b[31];
    ea = {1'b0, a[30:23]}; eb = {1'b0, b[30:23]};
    ma = {9'd0, a[22:0]}; mb = {9'd0, b[22:0]};
    if (ea != 0) ma[23] = 1'b1; else ea = 9'd1;
    if (eb != 0) mb[23] = 1'b1; else eb = 9'd1;
    if (ea >= eb) begin
      shift_amt = {23'd0, ea - eb}; if (shift_amt > 31) shift_amt = 32'd31;
      mb = mb >> shift_amt; e = ea;
    end else begin
      shift_amt = {23'd0, eb - ea}; if (shift_amt > 31) shift_amt = 32'd31;
      ma = ma >> shift_amt; e = eb;
    end
    if (sa == sb) begin
      sig = ma + mb; s = sa;
    end else if (ma > mb) begin
      sig = ma - mb; s = sa;
    end else if (mb > ma) begin
      sig = mb - ma; s = sb;
    end else begin
      return 32'd0;
    end
    if (sig == 0) return 32'd0;
    top = 24;
    while (top > 0 && sig[top] == 1'b0) top--;
    if (top == 24) begin
      sig = sig >> 1; e = e + 9'd1;
    end else if (top < 23) begin
      need = 9'(23 - top);
      if (e > need) begin
        sig = sig << need; e = e - need;
      end else begin
        sig = sig << (e - 9'd1); e = 9'd0;
      end
    end
    if (e >= 255) return {s, 8'hFF, 23'd0};
    return {s, e[7:0], sig[22:0]};
  endfunction

  task automatic report_mismatch(logic [31:0] got, logic [31:0] want);
    $display("mismatch: sum got %08h expected %08h", got, want);
    mismatches++;
  endtask

  task automatic report_mismatch_if(logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(got, want);
  endtask

  // Check each accepted result against the oldest prediction; drive stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (sum_queue.size() == 0) report_mismatch(sum_o, 32'hxxxxxxxx);
        else report_mismatch_if(sum_o, sum_queue.pop_front());
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("[binary32_float_adder_unit] ERROR");
      $finish;
    end
  end

  // Send one request, holding it until accepted.
  task automatic send_request(logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operand_a_i <= a;
    operand_b_i <= b;
    sum_queue = {sum_queue, predict_sum(a, b)};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_float();
    case ($urandom_range(5))
      0: return $urandom;
      1: return {1'($urandom_range(1)), 8'd0, 23'($urandom)};
      2: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(3))};
      3: return {1'($urandom_range(1)), 8'($urandom_range(120, 134)), 23'($urandom)};
      4: return {1'($urandom_range(1)), 8'($urandom_range(250, 254)), 23'($urandom)};
      default: return {1'($urandom_range(1)), 8'($urandom_range(0, 3)), 23'($urandom)};
    endcase
  endfunction

  task automatic test_directed();
    send_request(32'h0000_0000, 32'h3F80_0000); // zero passes b
    send_request(32'hC040_0000, 32'h0000_0000); // zero passes a
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'h8000_0000, 32'h8000_0000); // negative zeros
    send_request(32'h8000_0000, 32'h3F80_0000);
    send_request(32'h3F80_0000, 32'hBF80_0000); // exact cancellation
    send_request(32'h3F80_0000, 32'h3F80_0000); // carry out
    send_request(32'h3FFF_FFFF, 32'h3FFF_FFFF);
    send_request(32'h7F7F_FFFF, 32'h7F7F_FFFF); // overflow
    send_request(32'hFF00_0000, 32'hFF7F_FFFF);
    send_request(32'h7F80_0000, 32'h3F80_0000); // infinity operand
    send_request(32'h7FC0_0001, 32'hFFFF_FFFF); // nan patterns
    send_request(32'h0080_0000, 32'h8000_0001); // underflow to subnormal
    send_request(32'h0000_0001, 32'h0000_0001);
    send_request(32'h007F_FFFF, 32'h0000_0001);
    send_request(32'h0100_0000, 32'h80FF_FFFF);
    send_request(32'h3F80_0001, 32'hBF80_0000); // deep cancellation
    send_request(32'h7F00_0000, 32'h0000_0001); // shift capped
    send_request(32'h4B80_0000, 32'h3F80_0000);
    send_request(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    end_burst();
  endtask

  task automatic test_random(int unsigned count);
    logic [31:0] a;
    for (int unsigned i = 0; i < count; i++) begin
      a = rand_float();
      if ($urandom_range(3) == 0) send_request(a, a ^ 32'h8000_0000 ^ $urandom_range(3));
      else send_request(a, rand_float());
    end
    end_burst();
  endtask

  task automatic set_phase(int unsigned idle, int unsigned stall);
    idle_pct = idle;
    stall_pct = stall;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    set_phase(0, 0);   test_random(140);
    set_phase(69, 0);  test_random(130);
    set_phase(0, 69);  test_random(130);
    set_phase(28, 28); test_random(130);
    set_phase(0, 0);
    while (sum_queue.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("[binary32_float_adder_unit] OK");
    else $display("[binary32_float_adder_unit] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bfa_pkg.sv
hw/rtl/binary32_float_adder_unit.sv
tb/sv/tb.sv
